// ===== hw/rtl/dht_pkg.sv =====
// Package for the deadline handle table: operation and status codes, the
// queue entry type and the result type. Used by every module of the block but dht_ram.
package dht_pkg;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_SLEEP_REL   = 4'd0;
	localparam logic [OP_W-1:0] OP_SLEEP_MS    = 4'd1;
	localparam logic [OP_W-1:0] OP_SLEEP_UNTIL = 4'd2;
	localparam logic [OP_W-1:0] OP_YIELD       = 4'd3;
	localparam logic [OP_W-1:0] OP_SET_RESULT  = 4'd4;
	localparam logic [OP_W-1:0] OP_READ        = 4'd5;
	localparam logic [OP_W-1:0] OP_POLL        = 4'd6;
	localparam logic [OP_W-1:0] OP_AWAIT       = 4'd7;
	localparam logic [OP_W-1:0] OP_START       = 4'd8;

	localparam logic [1:0] ST_WAITING = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [63:0] MS_TO_US = 64'd1000;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ALLOC,
		KIND_SET,
		KIND_READ,
		KIND_POLL,
		KIND_AWAIT,
		KIND_START
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        is_yield;
		logic [63:0] deadline;
		logic [63:0] now_us;
		logic [7:0]  handle;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  new_handle;
		logic [1:0]  status;
		logic [31:0] result_word;
		logic [7:0]  completed;
		logic        not_started;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_SWEEP,
		BK_READ,
		BK_CLEAR,
		BK_OUT
	} bk_state_t;

endpackage

// ===== hw/rtl/deadline_handle_table_top.sv =====
// Top level of the deadline handle table: front end, back end and result
// queue. Uses dht_pkg, dht_front, dht_back and dht_outq.
//
// Usage: push an item with push while full is low; take results with pop
// while empty is low. Every item yields exactly one result, in order.
// The front end computes the deadline of each item (the millisecond
// product is split into two 32-bit multiplies) and then hands it to the
// back end; it takes no new item until then. Allocation scans slots from 1
// upward, one per cycle, up to slot SLOTS-1. Once started, poll sweeps slots
// 1 to SLOTS-1 through the deadline RAM read port, and await runs the same
// sweep before reading its handle; start clears the flag bits and sets the
// started flag.
// Reset empties the table and clears the started flag; the deadline and
// result words need no clearing since allocation writes them.
// When the receiver stalls, up to two results wait in the result queue, the
// back end holds a third and the front end one more item, after which full
// stays high.
module deadline_handle_table_top import dht_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  op,
	input  logic [63:0] now_us,
	input  logic [63:0] amount,
	input  logic [7:0]  handle,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  new_handle,
	output logic [1:0]  status,
	output logic [31:0] result_word,
	output logic [7:0]  completed,
	output logic        not_started
);

	cmd_t cmd;
	logic cmd_valid, cmd_ready;
	res_t bres, ores;
	logic bres_valid, bres_ready;

	dht_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.now_us(now_us), .amount(amount), .handle(handle), .value(value),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	dht_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .res_valid(bres_valid), .res_ready(bres_ready), .res(bres));

	dht_outq u_outq (
		.clk(clk), .arst_n(arst_n), .in_valid(bres_valid), .in_ready(bres_ready),
		.in_res(bres), .empty(empty), .pop(pop), .out_res(ores));

	assign new_handle  = ores.new_handle;
	assign status      = ores.status;
	assign result_word = ores.result_word;
	assign completed   = ores.completed;
	assign not_started = ores.not_started;

`ifndef ASSERT_OFF
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3)
		else $error("status code out of range");
	a_handle_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> {1'b0, new_handle} < 9'(SLOTS))
		else $error("allocated handle beyond table");
	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_word)))
		else $error("waiting result changed");
`endif

endmodule

// ===== hw/rtl/dht_front.sv =====
// Front end of the deadline handle table: classifies each item and computes
// its deadline, using a registered multiply for milliseconds. Uses dht_pkg.
module dht_front import dht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  op,
	input  logic [63:0] now_us,
	input  logic [63:0] amount,
	input  logic [7:0]  handle,
	input  logic [31:0] value,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	logic        busy_q;
	logic [1:0]  phase_q;
	logic [3:0]  op_q;
	logic [63:0] now_q;
	logic [63:0] amt_q;
	logic [7:0]  hdl_q;
	logic [31:0] val_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	cmd_t        cmd_q;

	assign full = busy_q;
	assign cmd_valid = busy_q && (phase_q == 2'd3);
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
		end else if (!busy_q) begin
			if (push) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end
		end else begin
			case (phase_q)
				2'd0: phase_q <= 2'd1;
				2'd1: phase_q <= 2'd2;
				2'd2: phase_q <= 2'd3;
				default: if (cmd_ready) busy_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && push) begin
			op_q  <= op;
			now_q <= now_us;
			amt_q <= amount;
			hdl_q <= handle;
			val_q <= value;
		end
		if (busy_q && phase_q == 2'd0) begin
			lo_q <= {32'd0, amt_q[31:0]} * {54'd0, MS_TO_US[9:0]};
			hi_q <= {32'd0, amt_q[63:32]} * {54'd0, MS_TO_US[9:0]};
		end
		if (busy_q && phase_q == 2'd1) begin
			lo_q <= lo_q + {hi_q[31:0], 32'd0};
		end
		if (busy_q && phase_q == 2'd2) begin
			cmd_q.now_us   <= now_q;
			cmd_q.handle   <= hdl_q;
			cmd_q.value    <= val_q;
			cmd_q.is_yield <= (op_q == OP_YIELD);
			case (op_q)
				OP_SLEEP_REL:   cmd_q.deadline <= now_q + amt_q;
				OP_SLEEP_MS:    cmd_q.deadline <= now_q + lo_q;
				OP_SLEEP_UNTIL: cmd_q.deadline <= amt_q;
				default:        cmd_q.deadline <= 64'd0;
			endcase
			case (op_q)
				OP_SLEEP_REL, OP_SLEEP_MS, OP_SLEEP_UNTIL, OP_YIELD:
					cmd_q.kind <= KIND_ALLOC;
				OP_SET_RESULT: cmd_q.kind <= KIND_SET;
				OP_READ:       cmd_q.kind <= KIND_READ;
				OP_POLL:       cmd_q.kind <= KIND_POLL;
				OP_AWAIT:      cmd_q.kind <= KIND_AWAIT;
				OP_START:      cmd_q.kind <= KIND_START;
				default:       cmd_q.kind <= KIND_NONE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Has no dependencies.
module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/dht_back.sv =====
// Back end of the deadline handle table: per-slot flags in flip-flops, the
// deadline and result words in RAMs, swept one slot a cycle. Uses dht_pkg and dht_ram.
module dht_back import dht_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(SLOTS);

	bk_state_t   state_q, state_d;
	logic [SLOTS-1:0] used_q, yield_q, done_q;
	logic        started_q;
	logic [AW:0] idx_q;
	logic        rd_pend_q;
	logic [AW-1:0] rd_idx_s1;
	logic [7:0]  cnt_q;
	cmd_t        c_q;
	res_t        res_q;
	logic        hok;
	logic [AW-1:0] hidx;
	logic        dl_we, rs_we;
	logic [AW-1:0] dl_waddr, rs_waddr, dl_raddr, rs_raddr;
	logic [63:0] dl_wdata, dl_rdata;
	logic [31:0] rs_wdata, rs_rdata;

	assign hidx = c_q.handle[AW-1:0];
	assign hok = (c_q.handle != 8'd0) && ({1'b0, c_q.handle} < 9'(SLOTS))
		&& used_q[hidx];
	assign cmd_ready = (state_q == BK_IDLE);
	assign res_valid = (state_q == BK_OUT);
	assign res = res_q;

	dht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_dl (
		.clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
		.raddr(dl_raddr), .rdata(dl_rdata));
	dht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_rs (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.raddr(rs_raddr), .rdata(rs_rdata));

	assign dl_raddr = idx_q[AW-1:0];
	assign rs_raddr = hidx;

	always_comb begin
		state_d  = state_q;
		dl_we    = 1'b0;
		dl_waddr = idx_q[AW-1:0];
		dl_wdata = c_q.deadline;
		rs_we    = 1'b0;
		rs_waddr = idx_q[AW-1:0];
		rs_wdata = 32'd0;
		case (state_q)
			BK_IDLE: if (cmd_valid) begin
				case (cmd.kind)
					KIND_ALLOC:         state_d = BK_ALLOC;
					KIND_POLL:          state_d = BK_SWEEP;
					KIND_READ, KIND_SET, KIND_AWAIT: state_d = BK_READ;
					KIND_START:         state_d = BK_CLEAR;
					default:            state_d = BK_OUT;
				endcase
			end
			BK_ALLOC: begin
				if (idx_q[AW-1:0] == AW'(SLOTS - 1) || !used_q[idx_q[AW-1:0]])
					state_d = BK_OUT;
				if (!used_q[idx_q[AW-1:0]]) begin
					dl_we = 1'b1;
					rs_we = 1'b1;
				end
			end
			BK_READ: begin
				if (c_q.kind == KIND_SET) begin
					rs_we    = hok;
					rs_waddr = hidx;
					rs_wdata = c_q.value;
					state_d  = BK_OUT;
				end else if (c_q.kind == KIND_AWAIT && hok && idx_q == (AW+1)'(1)) begin
					state_d = BK_SWEEP;
				end else if (rd_pend_q) begin
					state_d = BK_OUT;
				end
			end
			BK_SWEEP: if (!started_q || (!rd_pend_q && idx_q == (AW+1)'(SLOTS)))
				state_d = (c_q.kind == KIND_AWAIT) ? BK_READ : BK_OUT;
			BK_CLEAR: state_d = BK_OUT;
			BK_OUT: if (res_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			used_q    <= '0;
			yield_q   <= '0;
			done_q    <= '0;
			started_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= 1'b0;
			case (state_q)
				BK_ALLOC: if (!used_q[idx_q[AW-1:0]] && idx_q != '0) begin
					used_q[idx_q[AW-1:0]]  <= 1'b1;
					yield_q[idx_q[AW-1:0]] <= c_q.is_yield;
					done_q[idx_q[AW-1:0]]  <= 1'b0;
				end
				BK_SWEEP: begin
					rd_pend_q <= started_q && idx_q < (AW+1)'(SLOTS);
					if (rd_pend_q && used_q[rd_idx_s1] && !done_q[rd_idx_s1]
						&& (yield_q[rd_idx_s1] || c_q.now_us >= dl_rdata))
						done_q[rd_idx_s1] <= 1'b1;
				end
				BK_READ: rd_pend_q <= !rd_pend_q && state_d == BK_READ;
				BK_CLEAR: begin
					used_q    <= '0;
					yield_q   <= '0;
					done_q    <= '0;
					started_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		case (state_q)
			BK_IDLE: begin
				c_q   <= cmd;
				idx_q <= (AW+1)'(1);
				cnt_q <= 8'd0;
				res_q <= '0;
			end
			BK_ALLOC: begin
				if (!used_q[idx_q[AW-1:0]])
					res_q.new_handle <= 8'(idx_q);
				idx_q <= idx_q + 1'b1;
			end
			BK_SWEEP: begin
				if (idx_q < (AW+1)'(SLOTS)) idx_q <= idx_q + 1'b1;
				if (rd_pend_q && used_q[rd_idx_s1] && !done_q[rd_idx_s1]
					&& (yield_q[rd_idx_s1] || c_q.now_us >= dl_rdata))
					cnt_q <= cnt_q + 8'd1;
				res_q.not_started <= !started_q;
				if (state_d != BK_SWEEP) res_q.completed <= cnt_q
					+ ((rd_pend_q && used_q[rd_idx_s1] && !done_q[rd_idx_s1]
					&& (yield_q[rd_idx_s1] || c_q.now_us >= dl_rdata)) ? 8'd1 : 8'd0);
			end
			BK_READ: if (c_q.kind == KIND_READ || c_q.kind == KIND_AWAIT) begin
				if (!hok) begin
					res_q.status      <= ST_INVALID;
					res_q.result_word <= 32'd0;
					res_q.completed   <= 8'd0;
					res_q.not_started <= 1'b0;
				end else begin
					res_q.status      <= done_q[hidx] ? ST_DONE : ST_WAITING;
					res_q.result_word <= rs_rdata;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/dht_outq.sv =====
// Two-entry result queue between the back end and the result ports.
// Uses dht_pkg for the result type.
module dht_outq import dht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic empty,
	input  logic pop,
	output res_t out_res
);

	res_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign out_res = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_res;
	end

endmodule

// ===== tb/deadline_handle_table_top_test.sv =====
// Testbench for deadline_handle_table_top: a clocked driver feeds items from a
// queue, a built-in table model predicts each result and a monitor checks them.
// Depends on dht_pkg and the deadline_handle_table_top RTL only.
module deadline_handle_table_top_test import dht_pkg::*; ();

	localparam int NSLOT = 64;
	localparam int N_RANDOM = 820;

	typedef struct {
		logic [3:0]  op;
		logic [63:0] now_us;
		logic [63:0] amount;
		logic [7:0]  handle;
		logic [31:0] value;
	} item_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [3:0]  op;
	logic [63:0] now_us;
	logic [63:0] amount;
	logic [7:0]  handle;
	logic [31:0] value;
	logic        empty;
	logic        pop;
	logic [7:0]  new_handle;
	logic [1:0]  status;
	logic [31:0] result_word;
	logic [7:0]  completed;
	logic        not_started;

	deadline_handle_table_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.now_us(now_us), .amount(amount), .handle(handle), .value(value),
		.empty(empty), .pop(pop), .new_handle(new_handle), .status(status),
		.result_word(result_word), .completed(completed), .not_started(not_started)
	);

	item_t pending_items[$];
	res_t  expected_results[$];
	int    items_sent;
	int    total_items;
	int    errors;

	logic        tbl_used[NSLOT];
	logic        tbl_yield[NSLOT];
	logic [1:0]  tbl_status[NSLOT];
	logic [63:0] tbl_deadline[NSLOT];
	logic [31:0] tbl_result[NSLOT];
	logic        tbl_started;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [7:0] table_alloc(logic is_yield, logic [63:0] dl);
		for (int i = 1; i < NSLOT; i++) begin
			if (!tbl_used[i]) begin
				tbl_used[i] = 1'b1;
				tbl_yield[i] = is_yield;
				tbl_status[i] = ST_WAITING;
				tbl_deadline[i] = dl;
				tbl_result[i] = '0;
				return 8'(i);
			end
		end
		return 8'd0;
	endfunction

	function automatic void table_sweep(logic [63:0] t, ref res_t r);
		logic [7:0] n;
		n = '0;
		if (!tbl_started) begin
			r.not_started = 1'b1;
			return;
		end
		for (int i = 1; i < NSLOT; i++) begin
			if (tbl_used[i] && tbl_status[i] == ST_WAITING && (tbl_yield[i] || t >= tbl_deadline[i])) begin
				tbl_status[i] = ST_DONE;
				n++;
			end
		end
		r.completed = n;
	endfunction

	function automatic bit handle_valid(logic [7:0] h);
		return h != 0 && h < NSLOT && tbl_used[h];
	endfunction

	function automatic void table_clear();
		for (int i = 0; i < NSLOT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_yield[i] = 1'b0;
			tbl_status[i] = ST_WAITING;
			tbl_deadline[i] = '0;
			tbl_result[i] = '0;
		end
	endfunction

	function automatic res_t table_step(item_t it);
		res_t r;
		r = '0;
		case (it.op)
			OP_SLEEP_REL: r.new_handle = table_alloc(1'b0, it.now_us + it.amount);
			OP_SLEEP_MS: r.new_handle = table_alloc(1'b0, it.now_us + it.amount * MS_TO_US);
			OP_SLEEP_UNTIL: r.new_handle = table_alloc(1'b0, it.amount);
			OP_YIELD: r.new_handle = table_alloc(1'b1, 64'd0);
			OP_SET_RESULT: if (handle_valid(it.handle)) tbl_result[it.handle] = it.value;
			OP_READ, OP_AWAIT: begin
				if (handle_valid(it.handle)) begin
					if (it.op == OP_AWAIT) table_sweep(it.now_us, r);
					r.status = tbl_status[it.handle];
					r.result_word = tbl_result[it.handle];
				end else begin
					r.status = ST_INVALID;
				end
			end
			OP_POLL: table_sweep(it.now_us, r);
			OP_START: begin
				table_clear();
				tbl_started = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void field_check(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	function automatic void phase_rates(output int tx_idle, output int rx_idle);
		if (items_sent < total_items / 3) begin
			tx_idle = 31;
			rx_idle = 75;
		end else if (items_sent < 2 * total_items / 3) begin
			tx_idle = 75;
			rx_idle = 31;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t it;
		int tx_idle, rx_idle;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				it.op = op;
				it.now_us = now_us;
				it.amount = amount;
				it.handle = handle;
				it.value = value;
				expected_results.push_back(table_step(it));
				items_sent++;
			end
			if (!push || !full) begin
				phase_rates(tx_idle, rx_idle);
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
					it = pending_items.pop_front();
					op <= it.op;
					now_us <= it.now_us;
					amount <= it.amount;
					handle <= it.handle;
					value <= it.value;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		int tx_idle, rx_idle;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual handle %0h", $time,
						new_handle);
					errors++;
				end else begin
					e = expected_results.pop_front();
					field_check("new_handle", e.new_handle, new_handle);
					field_check("status", e.status, status);
					field_check("result_word", e.result_word, result_word);
					field_check("completed", e.completed, completed);
					field_check("not_started", e.not_started, not_started);
				end
			end
			phase_rates(tx_idle, rx_idle);
			pop <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	function automatic item_t mk(logic [3:0] o, logic [63:0] t, logic [63:0] a, logic [7:0] h,
			logic [31:0] v);
		item_t it;
		it.op = o;
		it.now_us = t;
		it.amount = a;
		it.handle = h;
		it.value = v;
		return it;
	endfunction

	initial begin
		logic [63:0] clock_us;
		logic [63:0] t, a;
		logic [3:0] o;
		int r;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		op = '0;
		now_us = '0;
		amount = '0;
		handle = '0;
		value = '0;
		errors = 0;
		items_sent = 0;
		table_clear();
		tbl_started = 1'b0;

		pending_items.push_back(mk(OP_YIELD, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_POLL, 64'd5, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_AWAIT, 64'd5, 64'd0, 8'd1, 32'd0));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_START, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_SLEEP_REL, '1, 64'd2, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_SLEEP_MS, 64'd100, '1, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_SLEEP_UNTIL, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_SLEEP_UNTIL, 64'd0, '1, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_YIELD, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_SET_RESULT, 64'd0, 64'd0, 8'd1, '1));
		pending_items.push_back(mk(OP_SET_RESULT, 64'd0, 64'd0, 8'd200, 32'h1234));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd1, 32'd0));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd255, 32'd0));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd64, 32'd0));
		pending_items.push_back(mk(OP_AWAIT, 64'd0, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_AWAIT, 64'd3, 64'd0, 8'd1, 32'd0));
		pending_items.push_back(mk(OP_POLL, '1, 64'd0, 8'd0, 32'd0));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd3, 32'd0));
		pending_items.push_back(mk(4'd9, '1, '1, '1, '1));
		pending_items.push_back(mk(4'd15, '1, '1, '1, '1));
		pending_items.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd63, 32'd0));

		clock_us = 64'd0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 99) < 1) begin
				for (int k = 0; k < 66; k++)
					pending_items.push_back(mk(OP_YIELD, clock_us, 64'd0, 8'd0, 32'd0));
				n += 66;
			end
			r = $urandom_range(0, 99);
			if (r < 12) o = OP_SLEEP_REL;
			else if (r < 20) o = OP_SLEEP_MS;
			else if (r < 28) o = OP_SLEEP_UNTIL;
			else if (r < 38) o = OP_YIELD;
			else if (r < 50) o = OP_SET_RESULT;
			else if (r < 62) o = OP_READ;
			else if (r < 78) o = OP_POLL;
			else if (r < 90) o = OP_AWAIT;
			else if (r < 92) o = OP_START;
			else o = 4'($urandom_range(9, 15));
			clock_us += $urandom_range(0, 2000);
			t = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : clock_us;
			r = $urandom_range(0, 99);
			if (r < 80) a = $urandom_range(0, 5000);
			else if (r < 90) a = $urandom_range(0, 5);
			else a = {$urandom, $urandom};
			if (o == OP_SLEEP_UNTIL && r < 80) a = clock_us + a;
			pending_items.push_back(mk(o, t, a,
				($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255)),
				$urandom));
		end
		total_items = pending_items.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || push || expected_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("deadline_handle_table_top_test: clean");
		else
			$display("deadline_handle_table_top_test: errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("deadline_handle_table_top_test: errors");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/dht_pkg.sv
hw/rtl/dht_front.sv
hw/rtl/dht_ram.sv
hw/rtl/dht_back.sv
hw/rtl/dht_outq.sv
hw/rtl/deadline_handle_table_top.sv
tb/deadline_handle_table_top_test.sv
